// File: rtl/tms_pkg.sv
`default_nettype none
package tms_pkg;

  // coordinates per triangle: v0 xyz, v1 xyz, v2 xyz
  localparam int NUM_COORD = 9;
  localparam int NUM_AXES  = 3;

  // child selected by one base-4 path digit
  typedef enum logic [1:0] {
    CHILD_CORNER_A = 2'd0,  // (A, AB, CA)
    CHILD_CORNER_B = 2'd1,  // (AB, B, BC)
    CHILD_CORNER_C = 2'd2,  // (CA, BC, C)
    CHILD_CENTER   = 2'd3   // (AB, BC, CA)
  } child_t;

endpackage
`default_nettype wire

// File: rtl/triangle_midpoint_subdivider_unit.sv
`default_nettype none
// Midpoint triangle subdivider. Each accepted triangle (three vertices, signed
// Q16.8 coordinates) is split into 4^L sub-triangles, L = subdivision_factor-1
// (none at factor 0 or 1, capped at MAX_LEVELS). Results leave in path order,
// first level as the most significant base-4 digit; last_of_run marks the
// final one. Midpoints are floor((P+Q)/2) per coordinate. One midpoint unit
// builds one child triangle per cycle, while no result waits at the output,
// from a per-level triangle stack, and between results only the levels whose
// path digit changed are rebuilt. An input is taken only while the block is
// idle. For each result the changed levels are rebuilt one at a time, and the
// result then waits in the output register until out_ready takes it; factor
// 0 or 1 passes the input straight to the output register. subdivision_factor
// must be written only while idle; cfg_ready is always high.
module triangle_midpoint_subdivider_unit
  import tms_pkg::*;
#(
  parameter int COORD_WIDTH = 24,
  parameter int MAX_LEVELS  = 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [2:0]                    cfg_data,

  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] in_v0_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_v0_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_v0_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_v1_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_v1_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_v1_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_v2_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_v2_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_v2_z,

  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0]      out_v0_x,
  output logic signed [COORD_WIDTH-1:0]      out_v0_y,
  output logic signed [COORD_WIDTH-1:0]      out_v0_z,
  output logic signed [COORD_WIDTH-1:0]      out_v1_x,
  output logic signed [COORD_WIDTH-1:0]      out_v1_y,
  output logic signed [COORD_WIDTH-1:0]      out_v1_z,
  output logic signed [COORD_WIDTH-1:0]      out_v2_x,
  output logic signed [COORD_WIDTH-1:0]      out_v2_y,
  output logic signed [COORD_WIDTH-1:0]      out_v2_z,
  output logic                               last_of_run
);

  localparam int LW = $clog2(MAX_LEVELS + 1);  // level number 0..MAX_LEVELS
  localparam int KW = 2 * MAX_LEVELS;          // path index, one digit per level

  typedef logic [NUM_COORD-1:0][COORD_WIDTH-1:0] tri_vec_t;
  typedef enum logic [1:0] {S_IDLE, S_CALC, S_EMIT} state_t;

  state_t        state_r;
  logic [2:0]    factor_r;
  logic [LW-1:0] levels_r;   // levels latched for the current run
  logic [LW-1:0] lvl_r;      // level being built from
  logic [KW-1:0] k_r;        // path index of the pending result
  tri_vec_t      lvl_tri_r [MAX_LEVELS+1];  // triangle stack, one per level
  tri_vec_t      out_tri_r;
  logic          out_valid_r;
  logic          last_r;

  tri_vec_t      in_tri;
  tri_vec_t      child;
  child_t        child_sel;
  logic [LW-1:0] levels_nxt;
  logic [LW-1:0] depth_sh;
  logic [LW-1:0] trail3;     // trailing path digits at 3
  logic          run3;
  logic          is_last;
  logic [1:0]    digit;

  assign in_tri = {in_v2_z, in_v2_y, in_v2_x,
                   in_v1_z, in_v1_y, in_v1_x,
                   in_v0_z, in_v0_y, in_v0_x};

  // levels = factor - 1, none at factor 0/1, saturated at MAX_LEVELS
  always_comb begin
    if (factor_r <= 3'd1) begin
      levels_nxt = '0;
    end else if (int'(factor_r) - 1 >= MAX_LEVELS) begin
      levels_nxt = LW'(MAX_LEVELS);
    end else begin
      levels_nxt = LW'(factor_r - 3'd1);
    end
  end

  // path digit for the level being built; level 0 is the top digit
  always_comb begin
    depth_sh = levels_r - lvl_r - LW'(1);
    digit    = 2'd0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (depth_sh == LW'(i)) digit = k_r[2*i +: 2];
    end
  end
  assign child_sel = child_t'(digit);

  // trailing 3s decide which levels change on the next index; all 3s = last
  always_comb begin
    trail3 = '0;
    run3   = 1'b1;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (run3 && (LW'(i) < levels_r) && (k_r[2*i +: 2] == 2'b11)) begin
        trail3 = trail3 + LW'(1);
      end else begin
        run3 = 1'b0;
      end
    end
    is_last = (trail3 == levels_r);
  end

  tms_mid_unit #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_mid (
    .parent    (lvl_tri_r[lvl_r]),
    .child_sel (child_sel),
    .child     (child)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      factor_r    <= 3'd1;
      levels_r    <= '0;
      lvl_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      if (cfg_valid) factor_r <= cfg_data;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            lvl_tri_r[0] <= in_tri;
            levels_r     <= levels_nxt;
            lvl_r        <= '0;
            k_r          <= '0;
            if (levels_nxt == '0) begin
              // pass-through: single result
              out_tri_r   <= in_tri;
              out_valid_r <= 1'b1;
              last_r      <= 1'b1;
              state_r     <= S_EMIT;
            end else begin
              state_r <= S_CALC;
            end
          end
        end
        S_CALC: begin
          lvl_tri_r[LW'(lvl_r + LW'(1))] <= child;
          if (lvl_r == levels_r - LW'(1)) begin
            out_tri_r   <= child;
            out_valid_r <= 1'b1;
            last_r      <= is_last;
            state_r     <= S_EMIT;
          end else begin
            lvl_r <= lvl_r + LW'(1);
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (last_r) begin
              state_r <= S_IDLE;
            end else begin
              // rebuild from the highest level whose digit changes
              k_r     <= k_r + KW'(1);
              lvl_r   <= levels_r - LW'(1) - trail3;
              state_r <= S_CALC;
            end
          end
        end
        default: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign cfg_ready   = 1'b1;
  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign last_of_run = last_r;
  assign out_v0_x    = out_tri_r[0];
  assign out_v0_y    = out_tri_r[1];
  assign out_v0_z    = out_tri_r[2];
  assign out_v1_x    = out_tri_r[3];
  assign out_v1_y    = out_tri_r[4];
  assign out_v1_z    = out_tri_r[5];
  assign out_v2_x    = out_tri_r[6];
  assign out_v2_y    = out_tri_r[7];
  assign out_v2_z    = out_tri_r[8];

  // no new triangle while a result is pending
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // level walk stays inside the latched depth
  a_lvl_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CALC) |-> (lvl_r < levels_r))
    else $error("level index beyond run depth");

  // the flagged transfer ends the run
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && last_of_run) |=> in_ready)
    else $error("run did not end after last transfer");

  // a subdivided triangle must build at least one level before its first result
  a_calc_before_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (levels_nxt != '0)) |=> !out_valid)
    else $error("result shown before any level was built");

endmodule
`default_nettype wire

// File: rtl/tms_mid_unit.sv
`default_nettype none
module tms_mid_unit
  import tms_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input  wire logic [NUM_COORD-1:0][COORD_WIDTH-1:0] parent,
  input  wire child_t                                 child_sel,
  output logic      [NUM_COORD-1:0][COORD_WIDTH-1:0] child
);

  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] ab, bc, ca;

  // floor((p+q)/2) on a sum one bit wider
  function automatic logic [COORD_WIDTH-1:0] half_sum(
    input logic [COORD_WIDTH-1:0] p,
    input logic [COORD_WIDTH-1:0] q
  );
    logic [COORD_WIDTH:0] s;
    s = {p[COORD_WIDTH-1], p} + {q[COORD_WIDTH-1], q};
    return s[COORD_WIDTH:1];
  endfunction

  always_comb begin
    for (int c = 0; c < NUM_AXES; c++) begin
      ab[c] = half_sum(parent[c], parent[NUM_AXES + c]);
      bc[c] = half_sum(parent[NUM_AXES + c], parent[2*NUM_AXES + c]);
      ca[c] = half_sum(parent[2*NUM_AXES + c], parent[c]);
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_AXES; c++) begin
      case (child_sel)
        CHILD_CORNER_A: begin
          child[c]              = parent[c];
          child[NUM_AXES + c]   = ab[c];
          child[2*NUM_AXES + c] = ca[c];
        end
        CHILD_CORNER_B: begin
          child[c]              = ab[c];
          child[NUM_AXES + c]   = parent[NUM_AXES + c];
          child[2*NUM_AXES + c] = bc[c];
        end
        CHILD_CORNER_C: begin
          child[c]              = ca[c];
          child[NUM_AXES + c]   = bc[c];
          child[2*NUM_AXES + c] = parent[2*NUM_AXES + c];
        end
        default: begin
          child[c]              = ab[c];
          child[NUM_AXES + c]   = bc[c];
          child[2*NUM_AXES + c] = ca[c];
        end
      endcase
    end
  end

endmodule
`default_nettype wire
